@@ rtl/core/bfr_pkg.sv @@
// shared types and constants for the bitstream field reader
`timescale 1ns / 1ps

package bfr_pkg;

	// buffer geometry
	localparam int BufferBits = 64;
	localparam int CntW       = $clog2(BufferBits + 1);
	localparam int MaxField   = 32;

	// request codes
	typedef enum logic [2:0] {
		REQ_PUSH  = 3'd0,
		REQ_GET   = 3'd1,
		REQ_SHOW  = 3'd2,
		REQ_ALIGN = 3'd3,
		REQ_CLEAR = 3'd4
	} req_code_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one request as captured at the input register
	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] byte_value;
		logic [5:0] bit_count;
	} req_t;

	// reader state
	typedef struct packed {
		logic [BufferBits-1:0] store;
		logic [CntW-1:0]       count;
		logic [31:0]           consumed;
	} state_t;

	// one result
	typedef struct packed {
		logic [31:0]     field_value;
		status_t         status;
		logic [CntW-1:0] bits_available;
		logic [31:0]     processed_bits;
	} result_t;

endpackage

@@ rtl/core/bfr_datapath.sv @@
// single-pass request datapath: next state and result for one request
`timescale 1ns / 1ps

module bfr_datapath (
	input  bfr_pkg::req_t    req,
	input  bfr_pkg::state_t  cur,
	output bfr_pkg::state_t  nxt,
	output bfr_pkg::result_t res
);

	logic [5:0]                     n;
	logic [bfr_pkg::CntW-1:0]       n_ext;
	logic [bfr_pkg::CntW-1:0]       sh;
	logic [bfr_pkg::BufferBits-1:0] shifted;
	logic [32:0]                    mask_w;
	logic [31:0]                    peek;
	logic [bfr_pkg::CntW:0]         push_sum;
	logic [2:0]                     drop;
	logic [31:0]                    value;
	bfr_pkg::status_t               status;

	// saturate the request length and extract the next bits
	always_comb begin
		n        = (req.bit_count > 6'(bfr_pkg::MaxField)) ? 6'(bfr_pkg::MaxField)
		                                                   : req.bit_count;
		n_ext    = bfr_pkg::CntW'(n);
		sh       = cur.count - n_ext;
		shifted  = cur.store >> sh;
		mask_w   = (33'd1 << n) - 33'd1;
		peek     = shifted[31:0] & mask_w[31:0];
		push_sum = {1'b0, cur.count} + (bfr_pkg::CntW + 1)'(8);
		drop     = cur.count[2:0];
	end

	// request decode and state update
	always_comb begin
		nxt    = cur;
		value  = '0;
		status = bfr_pkg::ST_OK;
		unique case (req.req_type)
			bfr_pkg::REQ_PUSH: begin
				if (push_sum > (bfr_pkg::CntW + 1)'(bfr_pkg::BufferBits)) begin
					status = bfr_pkg::ST_FULL;
				end else begin
					nxt.store = {cur.store[bfr_pkg::BufferBits-9:0], req.byte_value};
					nxt.count = push_sum[bfr_pkg::CntW-1:0];
				end
			end
			bfr_pkg::REQ_GET, bfr_pkg::REQ_SHOW: begin
				if (n_ext > cur.count) begin
					status = bfr_pkg::ST_SHORT;
				end else begin
					value = peek;
					if (req.req_type == bfr_pkg::REQ_GET) begin
						nxt.count    = cur.count - n_ext;
						nxt.consumed = cur.consumed + 32'(n);
					end
				end
			end
			bfr_pkg::REQ_ALIGN: begin
				nxt.count    = cur.count - bfr_pkg::CntW'(drop);
				nxt.consumed = cur.consumed + 32'(drop);
				value        = 32'(drop);
			end
			bfr_pkg::REQ_CLEAR: begin
				nxt.consumed = '0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// result fields
	always_comb begin
		res.field_value    = value;
		res.status         = status;
		res.bits_available = nxt.count;
		res.processed_bits = nxt.consumed;
	end

endmodule

@@ rtl/core/bitstream_field_reader_unit.sv @@
// top level of the msb-first bitstream field reader
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_valid, in_stall  | req_type, byte_value, bit_count
//  out     | out_valid, out_stall| field_value, status, bits_available, processed_bits
//
// each request passes through the input register and then the result register on its
// way to its result; one request is accepted every cycle while in_stall is low.
// the reader state updates as a request leaves the input register, so the next
// request sees it at once.
// arst_n clears the valids, the bit buffer, the bit count and the processed count.
// out_stall holds the result register; the input register fills and then stalls in.
`timescale 1ns / 1ps

module bitstream_field_reader_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [2:0]               req_type,
	input  logic [7:0]               byte_value,
	input  logic [5:0]               bit_count,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [31:0]              field_value,
	output logic [1:0]               status,
	output logic [bfr_pkg::CntW-1:0] bits_available,
	output logic [31:0]              processed_bits
);

	logic             valid_s1;
	bfr_pkg::req_t    req_s1;
	bfr_pkg::state_t  state_q;
	bfr_pkg::state_t  state_nxt;
	bfr_pkg::result_t res_nxt;
	bfr_pkg::result_t res_q;
	logic             out_valid_q;
	logic             advance;
	logic             fire;

	// flow control
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= '{req_type: req_type, byte_value: byte_value, bit_count: bit_count};
		end
	end

	// request datapath
	bfr_datapath u_datapath (
		.req (req_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// reader state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign field_value    = res_q.field_value;
	assign status         = res_q.status;
	assign bits_available = res_q.bits_available;
	assign processed_bits = res_q.processed_bits;

`ifndef SYNTHESIS
	// buffered bit count never exceeds the buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.count <= bfr_pkg::CntW'(bfr_pkg::BufferBits))
		else $error("bit count above buffer size");

	// the input side only stalls with a request held in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// a full status only comes when fewer than a byte of room is left
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == bfr_pkg::ST_FULL) |->
		(res_q.bits_available > bfr_pkg::CntW'(bfr_pkg::BufferBits - 8)))
		else $error("full status with room left");

	// a short status returns no bits
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == bfr_pkg::ST_SHORT) |-> (res_q.field_value == '0))
		else $error("short status with nonzero field");

	// the reader state only moves when a request passes to the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(fire) |-> $stable(state_q))
		else $error("state changed without a request");
`endif

endmodule
